// File: sv/gtp_pkg.sv
// Shared types and constants of the go-to-point drive controller.
// Used by the interfaces, the CORDIC cells, the back end and the top level.
package gtp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;
  localparam int HEAD_W           = 15;
  localparam int GAIN_W           = 16;
  localparam int DRIVE_W          = 8;
  localparam int ZW               = 25;
  localparam int PRESCALE_SH      = 14;
  localparam int ACC180           = 2949120;
  localparam int GAIN_INV         = 39797;
  localparam int DEG90            = 5760;
  localparam int DEG180           = 11520;
  localparam int DEG360           = 23040;
  localparam int RECIP15          = 2236962;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_X       = 3'd0,
    CFG_TARGET_Y       = 3'd1,
    CFG_TARGET_HEADING = 3'd2,
    CFG_MODE           = 3'd3,
    CFG_DRIVE_GAIN     = 3'd4,
    CFG_TURN_GAIN      = 3'd5,
    CFG_SPOT_GAIN      = 3'd6,
    CFG_ENABLE         = 3'd7
  } cfg_idx_e;

  typedef logic signed [ZW-1:0] angle_t;

  localparam logic signed [23:0] ATAN_TAB [24] = '{
    24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736, 24'sd58595, 24'sd29326,
    24'sd14667, 24'sd7334, 24'sd3667, 24'sd1833, 24'sd917, 24'sd458,
    24'sd229, 24'sd115, 24'sd57, 24'sd29, 24'sd14, 24'sd7,
    24'sd4, 24'sd2, 24'sd1, 24'sd0, 24'sd0, 24'sd0
  };

  typedef struct packed {
    logic              zero;
    logic [HEAD_W-1:0] cur;
  } item_ctl_t;

  typedef struct packed {
    logic              mode;
    logic              enable;
    logic [HEAD_W-1:0] target_heading;
    logic [GAIN_W-1:0] drive_gain;
    logic [GAIN_W-1:0] turn_gain;
    logic [GAIN_W-1:0] spot_gain;
  } cfg_t;

endpackage

// File: sv/gtp_if.sv
// Request channels of the go-to-point drive controller: pose in, commands out.
// Depends on gtp_pkg for field widths.
interface gtp_in_if #(parameter int COORD_BITS = gtp_pkg::COORD_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pos_x;
  logic signed [COORD_BITS-1:0]      pos_y;
  logic [gtp_pkg::HEAD_W-1:0]        current_heading;

  modport source (output valid, pos_x, pos_y, current_heading, input ready);
  modport sink   (input valid, pos_x, pos_y, current_heading, output ready);
endinterface

interface gtp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gtp_pkg::DRIVE_W-1:0] left_drive;
  logic signed [gtp_pkg::DRIVE_W-1:0] right_drive;
  logic                              velocity_kind;
  logic                              active;

  modport source (output valid, left_drive, right_drive, velocity_kind, active, input ready);
  modport sink   (input valid, left_drive, right_drive, velocity_kind, active, output ready);
endinterface

// File: sv/gtp_cordic_cell.sv
// One CORDIC vectoring step, registered; cells are chained one per iteration.
// Depends on gtp_pkg for the arctangent table and the control struct.
module gtp_cordic_cell #(
  parameter int IDX = 0,
  parameter int XW  = 33
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  gtp_pkg::item_ctl_t            ctl_i,
  input  logic signed [XW-1:0]          x_i,
  input  logic signed [XW-1:0]          y_i,
  input  gtp_pkg::angle_t               z_i,
  output logic                          valid_o,
  output gtp_pkg::item_ctl_t            ctl_o,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output gtp_pkg::angle_t               z_o
);
  import gtp_pkg::*;

  logic                 valid_q;
  item_ctl_t            ctl_q;
  logic signed [XW-1:0] x_q, y_q;
  angle_t               z_q;
  logic signed [XW-1:0] xs, ys;
  angle_t               step;

  assign xs   = x_i >>> IDX;
  assign ys   = y_i >>> IDX;
  assign step = ZW'(ATAN_TAB[IDX]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q <= ctl_i;
      if (y_i > 0) begin
        x_q <= x_i + ys;
        y_q <= y_i - xs;
        z_q <= z_i + step;
      end else begin
        x_q <= x_i - ys;
        y_q <= y_i + xs;
        z_q <= z_i - step;
      end
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
endmodule

// File: sv/gtp_post.sv
// Back end: bearing rounding, angle wrap, reverse choice, gains, spot turn,
// saturation and the output register. Depends on gtp_pkg.
module gtp_post #(
  parameter int XW = 33
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  gtp_pkg::item_ctl_t                ctl_i,
  input  logic signed [XW-1:0]              x_i,
  input  gtp_pkg::angle_t                   z_i,
  input  gtp_pkg::cfg_t                     cfg_i,
  output logic                              valid_o,
  output logic signed [gtp_pkg::DRIVE_W-1:0] left_o,
  output logic signed [gtp_pkg::DRIVE_W-1:0] right_o,
  output logic                              kind_o,
  output logic                              active_o
);
  import gtp_pkg::*;

  localparam int PW  = XW - 1 + 16;
  localparam int DSW = PW - 30;
  localparam int AW  = 18;
  localparam int DVW = DSW + 10;
  localparam int SW  = DSW + 11;
  localparam int TW  = 21;
  localparam logic signed [AW-1:0] A90  = AW'(DEG90);
  localparam logic signed [AW-1:0] A180 = AW'(DEG180);
  localparam logic signed [AW-1:0] A360 = AW'(DEG360);

  function automatic logic signed [DRIVE_W-1:0] sat8(input logic signed [SW-1:0] v);
    if (v > SW'(127)) return 8'sd127;
    if (v < -SW'(127)) return -8'sd127;
    return v[DRIVE_W-1:0];
  endfunction

  logic [6:1] v_q;
  item_ctl_t  ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;

  // stage 1
  angle_t                 zr;
  logic signed [ZW-9:0]   bear;
  logic signed [AW-1:0]   a1_d, a1_q;
  logic [PW-1:0]          xp1_d, xp1_q;
  // stage 2
  logic signed [AW-1:0]   a2_d, a2_q;
  logic [DSW-1:0]         dist2_d, dist2_q;
  // stage 3
  logic signed [AW-1:0]   absa_w, b_w, absb_w;
  logic                   rev3_d, rev3_q, neg3_q;
  logic [26:0]            mag1_d, mag1_q;
  logic [DSW+15:0]        drvp3_d, drvp3_q;
  // stage 4
  logic [42:0]            mag2_q;
  logic [DSW+7:0]         drvm4_q;
  logic                   rev4_q, neg4_q;
  // stage 5
  logic [21:0]            n5_q;
  logic [43:0]            q0_q;
  logic [DSW+7:0]         drvm5_q;
  logic                   rev5_q, neg5_q;
  // stage 6
  logic [18:0]            qs;
  logic [22:0]            prod15, rem;
  logic [18:0]            qf;
  logic signed [TW-1:0]   trn;
  logic signed [DVW-1:0]  drv;
  logic signed [DRIVE_W-1:0] pl, pr;
  logic [HEAD_W-1:0]      hdiff;
  logic [8:0]             diff;
  logic signed [10:0]     e;
  logic [9:0]             abse;
  logic [25:0]            sm;
  logic [6:0]             vsat;
  logic signed [DRIVE_W-1:0] sv;
  logic signed [DRIVE_W-1:0] left_d, right_d, left_q, right_q;
  logic                   kind_d, kind_q, active_q;

  always_comb begin
    zr    = z_i + ZW'(128);
    bear  = ctl_i.zero ? '0 : zr[ZW-1:8];
    a1_d  = AW'(bear) - AW'(signed'({1'b0, ctl_i.cur}));
    xp1_d = PW'(x_i[XW-2:0]) * PW'(GAIN_INV);
  end

  always_comb begin
    if (a1_q > A180) begin
      a2_d = a1_q - A360;
    end else if (a1_q >= -A180) begin
      a2_d = a1_q;
    end else if (a1_q + A360 >= -A180) begin
      a2_d = a1_q + A360;
    end else begin
      a2_d = a1_q + A360 + A360;
    end
    dist2_d = ctl1_q.zero ? '0 : xp1_q[PW-1:30];
  end

  always_comb begin
    absa_w = (a2_q < 0) ? -a2_q : a2_q;
    rev3_d = 1'b1;
    if (absa_w < A90) begin
      b_w    = a2_q;
      rev3_d = 1'b0;
    end else if (a2_q < 0) begin
      b_w = a2_q + A180;
    end else begin
      b_w = a2_q - A180;
    end
    absb_w  = (b_w < 0) ? -b_w : b_w;
    mag1_d  = 27'(absb_w[12:0]) * 27'(absa_w[13:0]);
    drvp3_d = (DSW+16)'(dist2_q) * (DSW+16)'(cfg_i.drive_gain);
  end

  always_comb begin
    qs     = q0_q[43:25];
    prod15 = {qs, 4'b0000} - 23'(qs);
    rem    = 23'(n5_q) - prod15;
    qf     = (rem >= 23'd15) ? qs + 19'd1 : qs;
    trn    = neg5_q ? -TW'(qf) : TW'(qf);
    drv    = rev5_q ? -DVW'(drvm5_q) : DVW'(drvm5_q);
    pl     = sat8(SW'(drv) + SW'(trn));
    pr     = sat8(SW'(drv) - SW'(trn));

    hdiff = (cfg_i.target_heading > ctl5_q.cur) ? cfg_i.target_heading - ctl5_q.cur
                                                : ctl5_q.cur - cfg_i.target_heading;
    diff  = hdiff[HEAD_W-1:6];
    if (cfg_i.target_heading < ctl5_q.cur) begin
      e = (diff < 9'd180) ? -11'(diff) : 11'sd360 - 11'(diff);
    end else begin
      e = (diff < 9'd180) ? 11'(diff) : 11'(diff) - 11'sd360;
    end
    abse = (e < 0) ? 10'(-e) : 10'(e);
    sm   = 26'(abse) * 26'(cfg_i.spot_gain);
    vsat = (sm[25:8] > 18'd127) ? 7'd127 : sm[14:8];
    sv   = (e < 0) ? -8'(vsat) : 8'(vsat);

    left_d  = '0;
    right_d = '0;
    kind_d  = 1'b0;
    if (cfg_i.enable && cfg_i.mode) begin
      left_d  = pl;
      right_d = pr;
    end else if (cfg_i.enable) begin
      left_d  = sv;
      right_d = -sv;
      kind_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[5:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl1_q   <= ctl_i;
      a1_q     <= a1_d;
      xp1_q    <= xp1_d;
      ctl2_q   <= ctl1_q;
      a2_q     <= a2_d;
      dist2_q  <= dist2_d;
      ctl3_q   <= ctl2_q;
      rev3_q   <= rev3_d;
      neg3_q   <= b_w < 0;
      mag1_q   <= mag1_d;
      drvp3_q  <= drvp3_d;
      ctl4_q   <= ctl3_q;
      mag2_q   <= 43'(mag1_q) * 43'(cfg_i.turn_gain);
      drvm4_q  <= drvp3_q[DSW+15:8];
      rev4_q   <= rev3_q;
      neg4_q   <= neg3_q;
      ctl5_q   <= ctl4_q;
      n5_q     <= mag2_q[42:21];
      q0_q     <= 44'(mag2_q[42:21]) * 44'(RECIP15);
      drvm5_q  <= drvm4_q;
      rev5_q   <= rev4_q;
      neg5_q   <= neg4_q;
      left_q   <= left_d;
      right_q  <= right_d;
      kind_q   <= kind_d;
      active_q <= cfg_i.enable;
    end
  end

  assign valid_o  = v_q[6];
  assign left_o   = left_q;
  assign right_o  = right_q;
  assign kind_o   = kind_q;
  assign active_o = active_q;
endmodule

// File: sv/go_to_point_drive_controller.sv
// Top level of the go-to-point drive controller: registers, front end,
// CORDIC cell chain and back end. Depends on gtp_pkg, gtp_if, gtp_cordic_cell, gtp_post.
//
// Usage: each pose request on in_ch (pos_x, pos_y, current_heading) yields one
// command request on out_ch (left_drive, right_drive, velocity_kind, active).
// Targets, mode, gains and enable are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while no request is in flight.
// The pipeline has one front-end stage, one stage per CORDIC cell and six back-end
// stages ending in the output register.
// Throughput is one request per cycle while the output is not stalled; the CORDIC
// chain and the back-end multipliers are fully pipelined.
// When out_ch.ready is low with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
// Reset clears all pipeline valids and loads the register reset values
// (gains 1.0, mode spot turn, output disabled).
module go_to_point_drive_controller
  import gtp_pkg::*;
#(
  parameter int CORDIC_STEPS = gtp_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = gtp_pkg::COORD_BITS_DEF,
  parameter int CFG_W        = (COORD_BITS > gtp_pkg::GAIN_W) ? COORD_BITS : gtp_pkg::GAIN_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gtp_in_if.sink                        in_ch,
  gtp_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [gtp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);
  localparam int DW = COORD_BITS + 1;
  localparam int XW = COORD_BITS + 17;
  localparam angle_t ZACC = ZW'(ACC180);

  logic signed [COORD_BITS-1:0] tx_q, ty_q;
  cfg_t                         cfg_q;
  logic                         adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q                 <= '0;
      ty_q                 <= '0;
      cfg_q.target_heading <= '0;
      cfg_q.mode           <= 1'b0;
      cfg_q.drive_gain     <= GAIN_W'(256);
      cfg_q.turn_gain      <= GAIN_W'(256);
      cfg_q.spot_gain      <= GAIN_W'(256);
      cfg_q.enable         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET_X:       tx_q                 <= cfg_data_i[COORD_BITS-1:0];
        CFG_TARGET_Y:       ty_q                 <= cfg_data_i[COORD_BITS-1:0];
        CFG_TARGET_HEADING: cfg_q.target_heading <= cfg_data_i[HEAD_W-1:0];
        CFG_MODE:           cfg_q.mode           <= cfg_data_i[0];
        CFG_DRIVE_GAIN:     cfg_q.drive_gain     <= cfg_data_i[GAIN_W-1:0];
        CFG_TURN_GAIN:      cfg_q.turn_gain      <= cfg_data_i[GAIN_W-1:0];
        CFG_SPOT_GAIN:      cfg_q.spot_gain      <= cfg_data_i[GAIN_W-1:0];
        CFG_ENABLE:         cfg_q.enable         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // front end: differences, prescale, half-plane prerotation
  logic signed [DW-1:0] dx, dy;
  logic signed [XW-1:0] x0, y0, xp_d, yp_d;
  angle_t               zp_d;
  item_ctl_t            ctlp_d;

  always_comb begin
    dx = DW'(tx_q) - DW'(in_ch.pos_x);
    dy = DW'(ty_q) - DW'(in_ch.pos_y);
    x0 = XW'(dy) <<< PRESCALE_SH;
    y0 = XW'(dx) <<< PRESCALE_SH;
    ctlp_d.zero = (dx == '0) && (dy == '0);
    ctlp_d.cur  = in_ch.current_heading;
    if (x0 < 0) begin
      zp_d = (y0 >= 0) ? ZACC : -ZACC;
      xp_d = -x0;
      yp_d = -y0;
    end else begin
      zp_d = '0;
      xp_d = x0;
      yp_d = y0;
    end
  end

  logic                 vc   [CORDIC_STEPS+1];
  item_ctl_t            ctlc [CORDIC_STEPS+1];
  logic signed [XW-1:0] xc   [CORDIC_STEPS+1];
  logic signed [XW-1:0] yc   [CORDIC_STEPS+1];
  angle_t               zc   [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc[0] <= 1'b0;
    end else if (adv) begin
      vc[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctlc[0] <= ctlp_d;
      xc[0]   <= xp_d;
      yc[0]   <= yp_d;
      zc[0]   <= zp_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    gtp_cordic_cell #(.IDX(i), .XW(XW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (vc[i]),
      .ctl_i   (ctlc[i]),
      .x_i     (xc[i]),
      .y_i     (yc[i]),
      .z_i     (zc[i]),
      .valid_o (vc[i+1]),
      .ctl_o   (ctlc[i+1]),
      .x_o     (xc[i+1]),
      .y_o     (yc[i+1]),
      .z_o     (zc[i+1])
    );
  end

  gtp_post #(.XW(XW)) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (vc[CORDIC_STEPS]),
    .ctl_i    (ctlc[CORDIC_STEPS]),
    .x_i      (xc[CORDIC_STEPS]),
    .z_i      (zc[CORDIC_STEPS]),
    .cfg_i    (cfg_q),
    .valid_o  (out_ch.valid),
    .left_o   (out_ch.left_drive),
    .right_o  (out_ch.right_drive),
    .kind_o   (out_ch.velocity_kind),
    .active_o (out_ch.active)
  );

  a_ready_follows_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not follow output stall");

  a_spot_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.velocity_kind |-> out_ch.right_drive == -out_ch.left_drive)
    else $error("spot turn commands not opposite");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.left_drive != -8'sd128 && out_ch.right_drive != -8'sd128)
    else $error("drive command outside saturation range");

  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.active |->
      out_ch.left_drive == '0 && out_ch.right_drive == '0 && !out_ch.velocity_kind)
    else $error("inactive result carries a command");
endmodule

// File: tb/tb.sv
// Self-checking testbench for go_to_point_drive_controller: drives pose requests, predicts
// the motor commands of each one in its own model and compares every output request.
// Depends on gtp_pkg, gtp_in_if, gtp_out_if and the controller RTL.
`timescale 1ns / 100ps

module tb;
  import gtp_pkg::*;

  typedef struct {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      velocity_kind;
    logic                      active;
  } command_t;

  localparam int IDLE_LIMIT = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  gtp_in_if  in_ch ();
  gtp_out_if out_ch ();

  go_to_point_drive_controller dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  longint   tgt_x, tgt_y, tgt_head, drive_mode, drive_gain, turn_gain, spot_gain, out_enable;
  command_t command_q[$];
  int       errors;
  int       burst_left;
  int       hold_cycles;
  int       idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint sat127(longint v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic command_t predict_command(longint px, longint py, longint cur);
    command_t c;
    longint dx, dy, cx, cy, z, nx, ny, bearing, distance, a, b, absa, drv, trn, des, diff, e, v;
    bit reverse;
    c = '{default: '0};
    c.active = out_enable[0];
    if (out_enable != 0 && drive_mode != 0) begin
      dx = tgt_x - px;
      dy = tgt_y - py;
      if (dx == 0 && dy == 0) begin
        bearing = 0;
        distance = 0;
      end else begin
        cx = dy * 16384;
        cy = dx * 16384;
        z = 0;
        if (cx < 0) begin
          z = (cy >= 0) ? ACC180 : -ACC180;
          cx = -cx;
          cy = -cy;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
          if (cy > 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            z += longint'(ATAN_TAB[i]);
          end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            z -= longint'(ATAN_TAB[i]);
          end
          cx = nx;
          cy = ny;
        end
        bearing = (z + 128) >>> 8;
        distance = (cx * GAIN_INV) >>> 30;
      end
      a = bearing - cur;
      while (a > DEG180) a -= DEG360;
      while (a < -DEG180) a += DEG360;
      absa = (a < 0) ? -a : a;
      reverse = 1'b0;
      if (absa < DEG90) begin
        b = a;
      end else if (a < 0) begin
        b = a + DEG180;
        reverse = 1'b1;
      end else begin
        b = a - DEG180;
        reverse = 1'b1;
      end
      drv = (distance * drive_gain) >>> 8;
      if (reverse) drv = -drv;
      if (absa > 57600) absa = 57600;
      trn = (b * turn_gain * absa) / 31457280;
      c.left_drive = sat127(drv + trn);
      c.right_drive = sat127(drv - trn);
    end else if (out_enable != 0) begin
      des = tgt_head;
      diff = ((des > cur) ? des - cur : cur - des) / 64;
      if (des < cur) e = (diff < 180) ? -diff : -(diff - 360);
      else e = (diff < 180) ? diff : diff - 360;
      v = sat127((e * spot_gain) / 256);
      c.left_drive = v;
      c.right_drive = -v;
      c.velocity_kind = 1'b1;
    end
    return c;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // hold the pose request until accepted; requests go in bursts, with a random idle gap after each burst
  task automatic send_pose(longint px, longint py, longint head);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px[15:0];
    in_ch.pos_y <= py[15:0];
    in_ch.current_heading <= head[14:0];
    do @(posedge clk_i); while (!in_ch.ready);
    command_q.push_back(predict_command(longint'($signed(px[15:0])),
                                        longint'($signed(py[15:0])),
                                        longint'(head[14:0])));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (command_q.size() == 0);
    repeat (CORDIC_STEPS_DEF + 12) @(posedge clk_i);
  endtask

  task automatic configure(longint tx, longint ty, longint th, longint md,
                           longint dg, longint tg, longint sg, longint en);
    longint vals[8];
    vals = '{tx, ty, th, md, dg, tg, sg, en};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i][15:0];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    tgt_x = longint'($signed(tx[15:0]));
    tgt_y = longint'($signed(ty[15:0]));
    tgt_head = th & 16'h7FFF;
    drive_mode = md & 1;
    drive_gain = dg & 16'hFFFF;
    turn_gain = tg & 16'hFFFF;
    spot_gain = sg & 16'hFFFF;
    out_enable = en & 1;
  endtask

  function automatic longint rand_coord();
    return longint'($signed(16'($urandom)));
  endfunction

  function automatic longint rand_heading();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(23040, 32767) : $urandom_range(0, 23039);
  endfunction

  task automatic test_disabled();
    send_pose(-32768, 32767, 0);
    send_pose(32767, -32768, 32767);
    send_pose(100, -100, 11520);
    drain();
  endtask

  task automatic test_spot_turns();
    configure(0, 0, 11520, 0, 256, 256, 256, 1);
    send_pose(0, 0, 0);
    send_pose(0, 0, 11520);
    send_pose(0, 0, 23039);
    send_pose(0, 0, 32767);
    drain();
    configure(0, 0, 0, 0, 256, 256, 65535, 1);
    send_pose(0, 0, 11520);
    send_pose(0, 0, 640);
    send_pose(0, 0, 63);
    drain();
  endtask

  task automatic test_point_drive();
    configure(0, 0, 0, 1, 256, 256, 256, 1);
    send_pose(0, 0, 0);
    send_pose(0, 100, 0);
    send_pose(0, -100, 0);
    send_pose(100, 0, 0);
    send_pose(-100, 0, 23039);
    send_pose(0, 32767, 32767);
    drain();
    configure(32767, 32767, 0, 1, 65535, 65535, 0, 1);
    send_pose(-32768, -32768, 0);
    send_pose(32767, -32768, 5760);
    send_pose(32767, 32767, 17280);
    drain();
    configure(-32768, -32768, 0, 1, 0, 0, 0, 1);
    send_pose(32767, 32767, 2880);
    send_pose(-32768, 32767, 11520);
    drain();
  endtask

  task automatic test_random_poses(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      configure(rand_coord(), rand_coord(), rand_heading(), $urandom_range(0, 3) != 0,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1024),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1024),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1024),
                $urandom_range(0, 7) != 0);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_pose(tgt_x + $signed($urandom_range(0, 400)) - 200,
                    tgt_y + $signed($urandom_range(0, 400)) - 200, rand_heading());
        else
          send_pose(rand_coord(), rand_coord(), rand_heading());
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    configure(1000, -2000, 300, 1, 512, 384, 256, 1);
    burst_left = 80;
    hold_cycles = 300;
    for (int i = 0; i < 60; i++) send_pose(rand_coord(), rand_coord(), rand_heading());
    drain();
  endtask

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int pattern;
    out_ch.ready = 1'b0;
    pattern = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) pattern = $urandom_range(0, 2);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        case (pattern)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 9) < 7);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    command_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (command_q.size() == 0) begin
        $display("unexpected command request at %0t", $realtime);
        errors++;
      end else begin
        want = command_q.pop_front();
        if (out_ch.left_drive !== want.left_drive)
          report_mismatch("left_drive", out_ch.left_drive, want.left_drive);
        if (out_ch.right_drive !== want.right_drive)
          report_mismatch("right_drive", out_ch.right_drive, want.right_drive);
        if (out_ch.velocity_kind !== want.velocity_kind)
          report_mismatch("velocity_kind", out_ch.velocity_kind, want.velocity_kind);
        if (out_ch.active !== want.active)
          report_mismatch("active", out_ch.active, want.active);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("go_to_point_drive_controller test failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    burst_left = 0;
    hold_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TARGET_X;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.current_heading = '0;
    tgt_x = 0;
    tgt_y = 0;
    tgt_head = 0;
    drive_mode = 0;
    drive_gain = 256;
    turn_gain = 256;
    spot_gain = 256;
    out_enable = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_spot_turns();
    test_point_drive();
    test_backpressure();
    test_random_poses(8, 45);
    if (errors == 0) begin
      $display("go_to_point_drive_controller test passed");
    end else begin
      $display("go_to_point_drive_controller test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/gtp_pkg.sv
sv/gtp_if.sv
sv/gtp_cordic_cell.sv
sv/gtp_post.sv
sv/go_to_point_drive_controller.sv
tb/tb.sv
